// ===== rtl/core/cau_pkg.sv =====
// Shared types and codes for the complex arithmetic unit.
package cau_pkg;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_MOD = 3'd4
	} op_e;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK  = 2'd0;
	localparam status_t ST_DZ  = 2'd1;
	localparam status_t ST_OVF = 2'd2;

	typedef struct packed {
		op_e  op;
		logic dz;
		logic big_re;
		logic big_im;
	} cau_ctl_t;

endpackage

// ===== rtl/core/cau_in_if.sv =====
// Operand channel: operation code and two complex operands.
interface cau_in_if #(
	parameter int DATA_WIDTH = 16
);
	logic                         valid;
	logic                         ready;
	logic [2:0]                   operation;
	logic signed [DATA_WIDTH-1:0] a_real;
	logic signed [DATA_WIDTH-1:0] a_imag;
	logic signed [DATA_WIDTH-1:0] b_real;
	logic signed [DATA_WIDTH-1:0] b_imag;

	modport source (output valid, operation, a_real, a_imag, b_real, b_imag, input ready);
	modport sink (input valid, operation, a_real, a_imag, b_real, b_imag, output ready);
endinterface

// ===== rtl/core/cau_out_if.sv =====
// Result channel: complex result and status.
interface cau_out_if #(
	parameter int DATA_WIDTH = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] result_real;
	logic signed [DATA_WIDTH-1:0] result_imag;
	logic [1:0]                   status;

	modport source (output valid, result_real, result_imag, status, input ready);
	modport sink (input valid, result_real, result_imag, status, output ready);
endinterface

// ===== rtl/core/cau_front.sv =====
// Front stages: products, sums, sign-magnitude split, divider setup and square-root setup.
module cau_front import cau_pkg::*; #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS = 8,
	localparam int W = DATA_WIDTH,
	localparam int PW = 2 * DATA_WIDTH,
	localparam int SW = 2 * DATA_WIDTH + 1,
	localparam int RW = 3 * DATA_WIDTH + FRAC_BITS + 2,
	localparam int SQW = 2 * DATA_WIDTH + 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [2:0]          en,
	input  logic                in_valid,
	input  logic [2:0]          operation,
	input  logic signed [W-1:0] a_real,
	input  logic signed [W-1:0] a_imag,
	input  logic signed [W-1:0] b_real,
	input  logic signed [W-1:0] b_imag,
	output logic [2:0]          vld,
	output cau_ctl_t            ctl_s3,
	output logic                neg_re_s3,
	output logic                neg_im_s3,
	output logic [RW-1:0]       rem_re_s3,
	output logic [RW-1:0]       rem_im_s3,
	output logic [PW-1:0]       den_s3,
	output logic [SQW-1:0]      sqx_s3
);

	op_e                  op_in;
	logic signed [W-1:0]  x0;
	logic signed [W-1:0]  x1;
	logic                 v_s1, v_s2, v_s3;
	op_e                  op_s1, op_s2;
	logic signed [PW-1:0] prr_s1, pii_s1, pri_s1, pir_s1, sq0_s1, sq1_s1;
	logic signed [W:0]    as_re_s1, as_im_s1;
	logic signed [SW-1:0] re_s2, im_s2;
	logic [PW-1:0]        den_s2;
	logic [SW-1:0]        mag_re, mag_im;
	logic [RW-1:0]        num_re, num_im, den_lim;

	assign op_in = op_e'(operation);
	assign x0 = (op_in == OP_MOD) ? a_real : b_real;
	assign x1 = (op_in == OP_MOD) ? a_imag : b_imag;
	assign vld = {v_s3, v_s2, v_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en[0]) v_s1 <= in_valid;
			if (en[1]) v_s2 <= v_s1;
			if (en[2]) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			op_s1 <= op_in;
			prr_s1 <= PW'(a_real) * PW'(b_real);
			pii_s1 <= PW'(a_imag) * PW'(b_imag);
			pri_s1 <= PW'(a_real) * PW'(b_imag);
			pir_s1 <= PW'(a_imag) * PW'(b_real);
			sq0_s1 <= PW'(x0) * PW'(x0);
			sq1_s1 <= PW'(x1) * PW'(x1);
			if (op_in == OP_SUB) begin
				as_re_s1 <= (W+1)'(a_real) - (W+1)'(b_real);
				as_im_s1 <= (W+1)'(a_imag) - (W+1)'(b_imag);
			end else begin
				as_re_s1 <= (W+1)'(a_real) + (W+1)'(b_real);
				as_im_s1 <= (W+1)'(a_imag) + (W+1)'(b_imag);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			op_s2 <= op_s1;
			den_s2 <= $unsigned(sq0_s1) + $unsigned(sq1_s1);
			case (op_s1) inside
				OP_ADD, OP_SUB: begin
					re_s2 <= SW'(as_re_s1);
					im_s2 <= SW'(as_im_s1);
				end
				OP_MUL: begin
					re_s2 <= SW'(prr_s1) - SW'(pii_s1);
					im_s2 <= SW'(pri_s1) + SW'(pir_s1);
				end
				OP_DIV: begin
					re_s2 <= SW'(prr_s1) + SW'(pii_s1);
					im_s2 <= SW'(pir_s1) - SW'(pri_s1);
				end
				default: begin
					re_s2 <= '0;
					im_s2 <= '0;
				end
			endcase
		end
	end

	always_comb begin
		mag_re = re_s2[SW-1] ? $unsigned(-re_s2) : $unsigned(re_s2);
		mag_im = im_s2[SW-1] ? $unsigned(-im_s2) : $unsigned(im_s2);
		num_re = RW'(mag_re) << FRAC_BITS;
		num_im = RW'(mag_im) << FRAC_BITS;
		den_lim = RW'(den_s2) << (W + 1);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			ctl_s3.op <= op_s2;
			ctl_s3.dz <= (op_s2 == OP_DIV) && (den_s2 == '0);
			ctl_s3.big_re <= (op_s2 == OP_DIV) && (num_re >= den_lim);
			ctl_s3.big_im <= (op_s2 == OP_DIV) && (num_im >= den_lim);
			neg_re_s3 <= re_s2[SW-1];
			neg_im_s3 <= im_s2[SW-1];
			rem_re_s3 <= (op_s2 == OP_DIV) ? num_re : RW'(mag_re);
			rem_im_s3 <= (op_s2 == OP_DIV) ? num_im : RW'(mag_im);
			den_s3 <= den_s2;
			sqx_s3 <= SQW'(den_s2);
		end
	end

endmodule

// ===== rtl/core/cau_iter.sv =====
// One pipelined step of the restoring divider and of the square root.
module cau_iter import cau_pkg::*; #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS = 8,
	parameter int STEP = 0,
	localparam int W = DATA_WIDTH,
	localparam int PW = 2 * DATA_WIDTH,
	localparam int QW = DATA_WIDTH + 1,
	localparam int RW = 3 * DATA_WIDTH + FRAC_BITS + 2,
	localparam int SQW = 2 * DATA_WIDTH + 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           v_in,
	input  cau_ctl_t       ctl_in,
	input  logic           neg_re_in,
	input  logic           neg_im_in,
	input  logic [RW-1:0]  rem_re_in,
	input  logic [RW-1:0]  rem_im_in,
	input  logic [QW-1:0]  q_re_in,
	input  logic [QW-1:0]  q_im_in,
	input  logic [PW-1:0]  den_in,
	input  logic [SQW-1:0] sqx_in,
	input  logic [SQW-1:0] sqr_in,
	output logic           v_sk,
	output cau_ctl_t       ctl_sk,
	output logic           neg_re_sk,
	output logic           neg_im_sk,
	output logic [RW-1:0]  rem_re_sk,
	output logic [RW-1:0]  rem_im_sk,
	output logic [QW-1:0]  q_re_sk,
	output logic [QW-1:0]  q_im_sk,
	output logic [PW-1:0]  den_sk,
	output logic [SQW-1:0] sqx_sk,
	output logic [SQW-1:0] sqr_sk
);

	logic [RW-1:0]  sub_t;
	logic [RW-1:0]  rem_re_n, rem_im_n;
	logic [QW-1:0]  q_re_n, q_im_n;
	logic [SQW-1:0] bit_t, trial;
	logic [SQW-1:0] sqx_n, sqr_n;
	logic           is_div, is_mod;

	always_comb begin
		is_div = (ctl_in.op == OP_DIV);
		is_mod = (ctl_in.op == OP_MOD);
		sub_t = RW'(den_in) << STEP;
		rem_re_n = rem_re_in;
		rem_im_n = rem_im_in;
		q_re_n = q_re_in;
		q_im_n = q_im_in;
		if (is_div && (rem_re_in >= sub_t)) begin
			rem_re_n = rem_re_in - sub_t;
			q_re_n[STEP] = 1'b1;
		end
		if (is_div && (rem_im_in >= sub_t)) begin
			rem_im_n = rem_im_in - sub_t;
			q_im_n[STEP] = 1'b1;
		end
		bit_t = SQW'(1) << (2 * STEP);
		trial = sqr_in + bit_t;
		sqx_n = sqx_in;
		sqr_n = sqr_in;
		if (is_mod) begin
			if (sqx_in >= trial) begin
				sqx_n = sqx_in - trial;
				sqr_n = (sqr_in >> 1) + bit_t;
			end else begin
				sqr_n = sqr_in >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sk <= 1'b0;
		end else if (en) begin
			v_sk <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_sk <= ctl_in;
			neg_re_sk <= neg_re_in;
			neg_im_sk <= neg_im_in;
			rem_re_sk <= rem_re_n;
			rem_im_sk <= rem_im_n;
			q_re_sk <= q_re_n;
			q_im_sk <= q_im_n;
			den_sk <= den_in;
			sqx_sk <= sqx_n;
			sqr_sk <= sqr_n;
		end
	end

endmodule

// ===== rtl/core/cau_finish.sv =====
// Output stage: rounding, saturation, status and the result register.
module cau_finish import cau_pkg::*; #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS = 8,
	localparam int W = DATA_WIDTH,
	localparam int PW = 2 * DATA_WIDTH,
	localparam int QW = DATA_WIDTH + 1,
	localparam int RW = 3 * DATA_WIDTH + FRAC_BITS + 2,
	localparam int SQW = 2 * DATA_WIDTH + 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           v_in,
	input  cau_ctl_t       ctl,
	input  logic           neg_re,
	input  logic           neg_im,
	input  logic [RW-1:0]  rem_re,
	input  logic [RW-1:0]  rem_im,
	input  logic [QW-1:0]  q_re,
	input  logic [QW-1:0]  q_im,
	input  logic [PW-1:0]  den,
	input  logic [SQW-1:0] sqx,
	input  logic [SQW-1:0] sqr,
	cau_out_if.source      out_ch
);

	localparam logic [RW-1:0] HALF = (FRAC_BITS > 0) ? (RW'(1) << (FRAC_BITS - 1)) : '0;
	localparam logic [RW-1:0] LIM = RW'(1) << (W - 1);

	logic [RW-1:0] mag_re, mag_im;
	logic [W:0]    sat_re, sat_im;
	logic          valid_q;
	logic [W-1:0]  re_q, im_q;
	status_t       status_q;
	status_t       status_n;
	logic [W-1:0]  re_n, im_n;

	function automatic logic [RW-1:0] lane_mag(input op_e op, input logic big,
			input logic [RW-1:0] rem, input logic [QW-1:0] q, input logic [PW-1:0] dv);
		logic [RW-1:0] m;
		case (op) inside
			OP_ADD, OP_SUB: m = rem;
			OP_MUL: m = (rem + HALF) >> FRAC_BITS;
			OP_DIV: m = big ? '1 : RW'(q) + RW'((rem << 1) >= RW'(dv));
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic logic [W:0] sat(input logic neg, input logic [RW-1:0] mag);
		logic [W:0] r;
		if (neg) begin
			if (mag > LIM) r = {1'b1, W'(LIM)};
			else r = {1'b0, W'(RW'(0) - mag)};
		end else begin
			if (mag > LIM - RW'(1)) r = {1'b1, W'(LIM - RW'(1))};
			else r = {1'b0, W'(mag)};
		end
		return r;
	endfunction

	always_comb begin
		if (ctl.op == OP_MOD) begin
			mag_re = RW'(sqr) + RW'(sqx > sqr);
			mag_im = '0;
		end else begin
			mag_re = lane_mag(ctl.op, ctl.big_re, rem_re, q_re, den);
			mag_im = lane_mag(ctl.op, ctl.big_im, rem_im, q_im, den);
		end
		sat_re = sat(neg_re && (mag_re != '0), mag_re);
		sat_im = sat(neg_im && (mag_im != '0), mag_im);
		if (ctl.dz) begin
			re_n = '0;
			im_n = '0;
			status_n = ST_DZ;
		end else begin
			re_n = sat_re[W-1:0];
			im_n = sat_im[W-1:0];
			status_n = (sat_re[W] || sat_im[W]) ? ST_OVF : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			re_q <= re_n;
			im_q <= im_n;
			status_q <= status_n;
		end
	end

	assign out_ch.valid = valid_q;
	assign out_ch.result_real = re_q;
	assign out_ch.result_imag = im_q;
	assign out_ch.status = status_q;

endmodule

// ===== rtl/core/complex_arithmetic_unit.sv =====
// Complex arithmetic unit top level: add, subtract, multiply, divide, modulus in signed fixed point.
// Throughput: one beat per cycle, unless out_ch.ready is low while every stage is full.
// Each divider and square-root step has its own stage,
// one per quotient bit, so DATA_WIDTH + 1 step stages follow three front stages.
// Each stage advances when empty or when the stage after it advances; bubbles collapse.
// Reset clears the valid bits only; data registers are not reset.
module complex_arithmetic_unit import cau_pkg::*; #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS = 8
) (
	input logic       clk,
	input logic       arst_n,
	cau_in_if.sink    in_ch,
	cau_out_if.source out_ch
);

	localparam int W = DATA_WIDTH;
	localparam int PW = 2 * DATA_WIDTH;
	localparam int QW = DATA_WIDTH + 1;
	localparam int RW = 3 * DATA_WIDTH + FRAC_BITS + 2;
	localparam int SQW = 2 * DATA_WIDTH + 2;
	localparam int NI = DATA_WIDTH + 1;
	localparam int NS = NI + 4;

	logic [NS-1:0]  vld;
	logic [NS-1:0]  en;
	cau_ctl_t       ctl_a [NI+1];
	logic           neg_re_a [NI+1];
	logic           neg_im_a [NI+1];
	logic [RW-1:0]  rem_re_a [NI+1];
	logic [RW-1:0]  rem_im_a [NI+1];
	logic [QW-1:0]  q_re_a [NI+1];
	logic [QW-1:0]  q_im_a [NI+1];
	logic [PW-1:0]  den_a [NI+1];
	logic [SQW-1:0] sqx_a [NI+1];
	logic [SQW-1:0] sqr_a [NI+1];

	for (genvar k = 0; k < NS; k++) begin : g_en
		assign en[k] = out_ch.ready | ~(&vld[NS-1:k]);
	end

	assign in_ch.ready = en[0];
	assign vld[NS-1] = out_ch.valid;
	assign q_re_a[0] = '0;
	assign q_im_a[0] = '0;
	assign sqr_a[0] = '0;

	cau_front #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en[2:0]),
		.in_valid(in_ch.valid),
		.operation(in_ch.operation),
		.a_real(in_ch.a_real),
		.a_imag(in_ch.a_imag),
		.b_real(in_ch.b_real),
		.b_imag(in_ch.b_imag),
		.vld(vld[2:0]),
		.ctl_s3(ctl_a[0]),
		.neg_re_s3(neg_re_a[0]),
		.neg_im_s3(neg_im_a[0]),
		.rem_re_s3(rem_re_a[0]),
		.rem_im_s3(rem_im_a[0]),
		.den_s3(den_a[0]),
		.sqx_s3(sqx_a[0])
	);

	for (genvar i = 0; i < NI; i++) begin : g_iter
		cau_iter #(
			.DATA_WIDTH(DATA_WIDTH),
			.FRAC_BITS(FRAC_BITS),
			.STEP(W - i)
		) u_iter (
			.clk(clk),
			.arst_n(arst_n),
			.en(en[i+3]),
			.v_in(vld[i+2]),
			.ctl_in(ctl_a[i]),
			.neg_re_in(neg_re_a[i]),
			.neg_im_in(neg_im_a[i]),
			.rem_re_in(rem_re_a[i]),
			.rem_im_in(rem_im_a[i]),
			.q_re_in(q_re_a[i]),
			.q_im_in(q_im_a[i]),
			.den_in(den_a[i]),
			.sqx_in(sqx_a[i]),
			.sqr_in(sqr_a[i]),
			.v_sk(vld[i+3]),
			.ctl_sk(ctl_a[i+1]),
			.neg_re_sk(neg_re_a[i+1]),
			.neg_im_sk(neg_im_a[i+1]),
			.rem_re_sk(rem_re_a[i+1]),
			.rem_im_sk(rem_im_a[i+1]),
			.q_re_sk(q_re_a[i+1]),
			.q_im_sk(q_im_a[i+1]),
			.den_sk(den_a[i+1]),
			.sqx_sk(sqx_a[i+1]),
			.sqr_sk(sqr_a[i+1])
		);
	end

	cau_finish #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_finish (
		.clk(clk),
		.arst_n(arst_n),
		.en(en[NS-1]),
		.v_in(vld[NS-2]),
		.ctl(ctl_a[NI]),
		.neg_re(neg_re_a[NI]),
		.neg_im(neg_im_a[NI]),
		.rem_re(rem_re_a[NI]),
		.rem_im(rem_im_a[NI]),
		.q_re(q_re_a[NI]),
		.q_im(q_im_a[NI]),
		.den(den_a[NI]),
		.sqx(sqx_a[NI]),
		.sqr(sqr_a[NI]),
		.out_ch(out_ch)
	);

endmodule

// ===== rtl/core/cau_checker.sv =====
// Port-level checks for the complex arithmetic unit and their binding.
module cau_checker import cau_pkg::*; #(
	parameter int DATA_WIDTH = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [DATA_WIDTH-1:0] result_real,
	input logic [DATA_WIDTH-1:0] result_imag,
	input logic [1:0]            status
);

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_DZ || status == ST_OVF))
		else $error("illegal status code");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_DZ) |-> (result_real == '0 && result_imag == '0))
		else $error("divide by zero with nonzero result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(result_real)
			&& $stable(result_imag) && $stable(status)))
		else $error("stalled result beat changed");

	a_accept_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

endmodule

bind complex_arithmetic_unit cau_checker #(
	.DATA_WIDTH(DATA_WIDTH)
) u_cau_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.result_real(out_ch.result_real),
	.result_imag(out_ch.result_imag),
	.status(out_ch.status)
);
